// File: src/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define GBYQ_AST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// property checked on every rising edge, reset included
`define GBYQ_AST_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gbyq_pkg.sv
`default_nettype none
package gbyq_pkg;

	// cordic x/y datapath word, q1.30 with headroom for gain and sums
	typedef logic signed [33:0] cw_t;
	// cordic angle accumulator, fraction of a turn with guard bit
	typedef logic signed [32:0] zw_t;

	localparam int MAX_STAGES = 30;

	localparam cw_t CORDIC_KGAIN = 34'sd652032874;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	// 1e-7 degree to turns: v * 2^22 / 3515625, reciprocal scaled by 2^31
	localparam logic [31:0] RECIP_M = 32'd2562047788;
	localparam logic [21:0] DIV_C = 22'd3515625;

	// arctangent of 2^-i as a fraction of a turn
	localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

endpackage
`default_nettype wire

// File: src/gps_bearing_to_yaw_quaternion.sv
// throughput: one item per cycle unless a held result stalls; each micro-rotation has
// its own register stage, and a held result freezes the whole pipeline until it is taken
// reset clears all valid bits and the cordic tag registers; other payload registers are not reset
`default_nettype none
module gps_bearing_to_yaw_quaternion #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] start_latitude,
	input  logic signed [31:0] start_longitude,
	input  logic signed [30:0] end_latitude,
	input  logic signed [31:0] end_longitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        yaw_turns,
	output logic [14:0]        quat_z,
	output logic signed [15:0] quat_w,
	output logic signed [30:0] datum_latitude,
	output logic signed [31:0] datum_longitude
);

	localparam int CS = CORDIC_STAGES;
	localparam logic [31:0] YAW_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	logic en;
	logic out_valid_q;

	// coordinate conversion
	logic [31:0] crd [4];
	logic [31:0] crd_mag [4];
	logic [31:0] cv_mag_s1 [4];
	logic        cv_neg_s1 [4];
	logic [63:0] cv_prod_s1 [4];
	logic [31:0] cv_mag_s2 [4];
	logic        cv_neg_s2 [4];
	logic [31:0] cv_q0_s2 [4];
	logic [53:0] cv_p2_s2 [4];
	logic [53:0] cv_rem [4];
	logic [31:0] cv_q [4];
	logic [31:0] ang_s3 [4];
	logic [31:0] sc_ang [3];
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [30:0] dlat_s1, dlat_s2, dlat_s3, dlat_s4;
	logic [31:0] dlon_s1, dlon_s2, dlon_s3, dlon_s4;

	// first sincos bank: lat1, lat2, dlon
	gbyq_pkg::cw_t sc_sin [3];
	gbyq_pkg::cw_t sc_cos [3];
	logic [63:0]   sc_tag;

	// bearing operands
	logic signed [67:0] p_y, p_x1, p_t, p_t2;
	gbyq_pkg::cw_t yc_s5, x1_s5, t_s5, cd_s5;
	gbyq_pkg::cw_t yc_s6, x1_s6, t2_s6;
	gbyq_pkg::cw_t yc_s7, xc_s7;
	logic          valid_s5, valid_s6, valid_s7;
	logic [62:0]   datum_s5, datum_s6, datum_s7;

	// vectoring pipeline
	gbyq_pkg::cw_t vx_s [CS+1];
	gbyq_pkg::cw_t vy_s [CS+1];
	gbyq_pkg::zw_t vz_s [CS+1];
	logic          vneg_s [CS+1];
	logic          vzero_s [CS+1];
	logic [63:0]   vtag_s [CS+1];

	// yaw and quaternion
	logic [31:0]   theta;
	logic [31:0]   yaw_s8;
	logic          valid_s8;
	logic [62:0]   datum_s8;
	logic [31:0]   qa_ang [1];
	gbyq_pkg::cw_t qa_sin [1];
	gbyq_pkg::cw_t qa_cos [1];
	logic [79:0]   qa_tag;
	logic signed [17:0] rz, rw;
	logic [14:0]   quat_z_q;
	logic signed [15:0] quat_w_q;
	logic [15:0]   yaw_turns_q;
	logic [62:0]   datum_q;

	// whole pipeline moves unless a held result is stalled
	assign en = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// magnitude of each coordinate
	always_comb begin
		crd[0] = {start_latitude[30], start_latitude};
		crd[1] = start_longitude;
		crd[2] = {end_latitude[30], end_latitude};
		crd[3] = end_longitude;
		for (int i = 0; i < 4; i++) crd_mag[i] = crd[i][31] ? (32'd0 - crd[i]) : crd[i];
	end

	// quotient correction
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cv_rem[i] = {cv_mag_s2[i], 22'd0} - cv_p2_s2[i];
			cv_q[i] = cv_q0_s2[i] + ((cv_rem[i] >= {32'd0, gbyq_pkg::DIV_C}) ? 32'd1 : 32'd0);
		end
	end

	// conversion payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				cv_mag_s1[i] <= crd_mag[i];
				cv_neg_s1[i] <= crd[i][31];
				cv_prod_s1[i] <= {32'd0, crd_mag[i]} * {32'd0, gbyq_pkg::RECIP_M};
				cv_mag_s2[i] <= cv_mag_s1[i];
				cv_neg_s2[i] <= cv_neg_s1[i];
				cv_q0_s2[i] <= cv_prod_s1[i][62:31];
				cv_p2_s2[i] <= {22'd0, cv_prod_s1[i][62:31]} * {32'd0, gbyq_pkg::DIV_C};
				ang_s3[i] <= cv_neg_s2[i] ? (32'd0 - cv_q[i]) : cv_q[i];
			end
			sc_ang[0] <= ang_s3[0];
			sc_ang[1] <= ang_s3[2];
			sc_ang[2] <= ang_s3[3] - ang_s3[1];
			dlat_s1 <= end_latitude;
			dlon_s1 <= end_longitude;
			dlat_s2 <= dlat_s1;
			dlon_s2 <= dlon_s1;
			dlat_s3 <= dlat_s2;
			dlon_s3 <= dlon_s2;
			dlat_s4 <= dlat_s3;
			dlon_s4 <= dlon_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	gbyq_cordic_rot #(
		.LANES(3),
		.STAGES(CS),
		.TAG_W(64)
	) u_sc (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.ang(sc_ang),
		.tag_in({valid_s4, dlat_s4, dlon_s4}),
		.sin_v(sc_sin),
		.cos_v(sc_cos),
		.tag_out(sc_tag)
	);

	// products, each floored back to q1.30
	assign p_y = sc_cos[1] * sc_sin[2];
	assign p_x1 = sc_cos[0] * sc_sin[1];
	assign p_t = sc_sin[0] * sc_cos[1];
	assign p_t2 = t_s5 * cd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			yc_s5 <= gbyq_pkg::cw_t'(p_y >>> 30);
			x1_s5 <= gbyq_pkg::cw_t'(p_x1 >>> 30);
			t_s5 <= gbyq_pkg::cw_t'(p_t >>> 30);
			cd_s5 <= sc_cos[2];
			datum_s5 <= sc_tag[62:0];
			yc_s6 <= yc_s5;
			x1_s6 <= x1_s5;
			t2_s6 <= gbyq_pkg::cw_t'(p_t2 >>> 30);
			datum_s6 <= datum_s5;
			yc_s7 <= yc_s6;
			xc_s7 <= x1_s6 - t2_s6;
			datum_s7 <= datum_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= sc_tag[63];
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// atan2 by vectoring, x made non-negative first
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0] <= xc_s7[33] ? -xc_s7 : xc_s7;
			vy_s[0] <= xc_s7[33] ? -yc_s7 : yc_s7;
			vz_s[0] <= '0;
			vneg_s[0] <= xc_s7[33];
			vzero_s[0] <= (xc_s7 == '0) && (yc_s7 == '0);
			for (int k = 0; k < CS; k++) begin
				vneg_s[k+1] <= vneg_s[k];
				vzero_s[k+1] <= vzero_s[k];
				if (!vy_s[k][33]) begin
					vx_s[k+1] <= vx_s[k] + (vy_s[k] >>> k);
					vy_s[k+1] <= vy_s[k] - (vx_s[k] >>> k);
					vz_s[k+1] <= vz_s[k] + $signed({1'b0, gbyq_pkg::ATAN_TURNS[k]});
				end else begin
					vx_s[k+1] <= vx_s[k] - (vy_s[k] >>> k);
					vy_s[k+1] <= vy_s[k] + (vx_s[k] >>> k);
					vz_s[k+1] <= vz_s[k] - $signed({1'b0, gbyq_pkg::ATAN_TURNS[k]});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CS; k++) vtag_s[k] <= '0;
		end else if (en) begin
			vtag_s[0] <= {valid_s7, datum_s7};
			for (int k = 0; k < CS; k++) vtag_s[k+1] <= vtag_s[k];
		end
	end

	// bearing to east-zero yaw, truncated to the kept bits
	assign theta = vzero_s[CS] ? 32'd0 :
		((vneg_s[CS] ? gbyq_pkg::HALF_TURN : 32'd0) + vz_s[CS][31:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s8 <= (gbyq_pkg::QUARTER_TURN - theta) & YAW_MASK;
			datum_s8 <= vtag_s[CS][62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s8 <= 1'b0;
		else if (en) valid_s8 <= vtag_s[CS][63];
	end

	assign qa_ang[0] = {1'b0, yaw_s8[31:1]};

	gbyq_cordic_rot #(
		.LANES(1),
		.STAGES(CS),
		.TAG_W(80)
	) u_qa (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.ang(qa_ang),
		.tag_in({valid_s8, yaw_s8[31:16], datum_s8}),
		.sin_v(qa_sin),
		.cos_v(qa_cos),
		.tag_out(qa_tag)
	);

	// round q1.30 to q1.14
	assign rz = 18'((qa_sin[0] + 34'sd32768) >>> 16);
	assign rw = 18'((qa_cos[0] + 34'sd32768) >>> 16);

	// output register with clamp
	always_ff @(posedge clk) begin
		if (en) begin
			if (rz < 18'sd0) quat_z_q <= 15'd0;
			else if (rz > 18'sd16384) quat_z_q <= 15'd16384;
			else quat_z_q <= rz[14:0];
			if (rw < -18'sd16384) quat_w_q <= -16'sd16384;
			else if (rw > 18'sd16384) quat_w_q <= 16'sd16384;
			else quat_w_q <= rw[15:0];
			yaw_turns_q <= qa_tag[78:63];
			datum_q <= qa_tag[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= qa_tag[79];
	end

	assign out_valid = out_valid_q;
	assign yaw_turns = yaw_turns_q;
	assign quat_z = quat_z_q;
	assign quat_w = quat_w_q;
	assign datum_latitude = datum_q[62:32];
	assign datum_longitude = datum_q[31:0];

endmodule
`default_nettype wire

// File: src/gbyq_cordic_rot.sv
`default_nettype none
module gbyq_cordic_rot #(
	parameter int LANES = 1,
	parameter int STAGES = 16,
	parameter int TAG_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [31:0]        ang [LANES],
	input  logic [TAG_W-1:0]   tag_in,
	output gbyq_pkg::cw_t      sin_v [LANES],
	output gbyq_pkg::cw_t      cos_v [LANES],
	output logic [TAG_W-1:0]   tag_out
);

	logic [31:0]     pre_a [LANES];
	logic            pre_neg [LANES];
	gbyq_pkg::cw_t   x_s [LANES][STAGES+1];
	gbyq_pkg::cw_t   y_s [LANES][STAGES+1];
	gbyq_pkg::zw_t   z_s [LANES][STAGES+1];
	logic            neg_s [LANES][STAGES+1];
	logic [TAG_W-1:0] tag_s [STAGES+1];

	// fold second and third quadrants by half a turn
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pre_neg[l] = (ang[l][31:30] == 2'b01) || (ang[l][31:30] == 2'b10);
			pre_a[l] = pre_neg[l] ? (ang[l] - gbyq_pkg::HALF_TURN) : ang[l];
		end
	end

	// rotation stages, one micro-rotation per register stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				x_s[l][0] <= gbyq_pkg::CORDIC_KGAIN;
				y_s[l][0] <= '0;
				z_s[l][0] <= $signed({pre_a[l][31], pre_a[l]});
				neg_s[l][0] <= pre_neg[l];
				for (int k = 0; k < STAGES; k++) begin
					neg_s[l][k+1] <= neg_s[l][k];
					if (!z_s[l][k][32]) begin
						x_s[l][k+1] <= x_s[l][k] - (y_s[l][k] >>> k);
						y_s[l][k+1] <= y_s[l][k] + (x_s[l][k] >>> k);
						z_s[l][k+1] <= z_s[l][k] - $signed({1'b0, gbyq_pkg::ATAN_TURNS[k]});
					end else begin
						x_s[l][k+1] <= x_s[l][k] + (y_s[l][k] >>> k);
						y_s[l][k+1] <= y_s[l][k] - (x_s[l][k] >>> k);
						z_s[l][k+1] <= z_s[l][k] + $signed({1'b0, gbyq_pkg::ATAN_TURNS[k]});
					end
				end
				sin_v[l] <= neg_s[l][STAGES] ? -y_s[l][STAGES] : y_s[l][STAGES];
				cos_v[l] <= neg_s[l][STAGES] ? -x_s[l][STAGES] : x_s[l][STAGES];
			end
		end
	end

	// sideband travels alongside, valid bit inside it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++) tag_s[k] <= '0;
			tag_out <= '0;
		end else if (en) begin
			tag_s[0] <= tag_in;
			for (int k = 0; k < STAGES; k++) tag_s[k+1] <= tag_s[k];
			tag_out <= tag_s[STAGES];
		end
	end

endmodule
`default_nettype wire

// File: src/gbyq_checker.sv
`default_nettype none
`include "assert_macros.svh"
module gbyq_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire [15:0]        yaw_turns,
	input wire [14:0]        quat_z,
	input wire signed [15:0] quat_w,
	input wire signed [30:0] datum_latitude,
	input wire signed [31:0] datum_longitude
);

	// no result shows while in reset
	`GBYQ_AST_RST(a_rst_quiet, clk, !arst_n |-> !out_valid, "result valid during reset")

	// input only held back by a stalled result
	`GBYQ_AST(a_stall_src, clk, arst_n, in_stall |-> (out_valid && out_stall), "input stalled without cause")

	// held result stays valid
	`GBYQ_AST(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")

	// held payload does not move
	`GBYQ_AST(a_out_stable, clk, arst_n, (out_valid && out_stall) |=> ($stable(yaw_turns) && $stable(quat_z) && $stable(quat_w) && $stable(datum_latitude) && $stable(datum_longitude)), "result changed while stalled")

	// quaternion stays on the unit range
	`GBYQ_AST(a_quat_range, clk, arst_n, out_valid |-> ((quat_z <= 15'd16384) && (quat_w >= -16'sd16384) && (quat_w <= 16'sd16384)), "quaternion out of range")

endmodule

bind gps_bearing_to_yaw_quaternion gbyq_checker u_gbyq_checker (.*);
`default_nettype wire

// File: tb/gps_bearing_to_yaw_quaternion_test.sv
`default_nettype none
module gps_bearing_to_yaw_quaternion_test;

	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int LATENCY = 3 * CORDIC_STAGES + 14;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [31:0] YAW_KEEP = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

	typedef struct packed {
		logic signed [30:0] lat1;
		logic signed [31:0] lon1;
		logic signed [30:0] lat2;
		logic signed [31:0] lon2;
	} fix_pair_t;

	typedef struct packed {
		logic [15:0]        yaw;
		logic [14:0]        qz;
		logic signed [15:0] qw;
		logic signed [30:0] dlat;
		logic signed [31:0] dlon;
	} heading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [30:0] start_latitude = '0;
	logic signed [31:0] start_longitude = '0;
	logic signed [30:0] end_latitude = '0;
	logic signed [31:0] end_longitude = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] yaw_turns;
	logic [14:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [30:0] datum_latitude;
	logic signed [31:0] datum_longitude;

	fix_pair_t pending_fixes[$];
	heading_t expected_headings[$];
	int fixes_sent = 0;
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	gps_bearing_to_yaw_quaternion #(
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_latitude(start_latitude),
		.start_longitude(start_longitude),
		.end_latitude(end_latitude),
		.end_longitude(end_longitude),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.yaw_turns(yaw_turns),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.datum_latitude(datum_latitude),
		.datum_longitude(datum_longitude)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// 1e-7 degree to fraction of a turn, truncated toward zero
	function automatic logic [31:0] deg7_turns(input longint v);
		longint q;
		q = (v * 64'sd2147483648) / 64'sd1800000000;
		return q[31:0];
	endfunction

	// rotation mode cordic, q1.30 sine and cosine
	function automatic void rotate_angle(input logic [31:0] ang, output longint s,
		output longint c);
		bit neg;
		longint x, y, z, dx, dy;
		neg = 1'b0;
		if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
			ang = ang - gbyq_pkg::HALF_TURN;
			neg = 1'b1;
		end
		z = longint'($signed(ang));
		x = longint'(gbyq_pkg::CORDIC_KGAIN);
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < gbyq_pkg::MAX_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(gbyq_pkg::ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(gbyq_pkg::ATAN_TURNS[i]);
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	// vectoring mode cordic, angle as a fraction of a turn
	function automatic logic [31:0] vector_angle(input longint y, input longint x);
		logic [31:0] base;
		longint z, dx, dy;
		base = '0;
		z = 0;
		if (x == 0 && y == 0)
			return '0;
		if (x < 0) begin
			x = -x; y = -y; base = gbyq_pkg::HALF_TURN;
		end
		for (int i = 0; i < CORDIC_STAGES && i < gbyq_pkg::MAX_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(gbyq_pkg::ATAN_TURNS[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(gbyq_pkg::ATAN_TURNS[i]);
			end
		end
		return base + z[31:0];
	endfunction

	function automatic longint round_q14(input longint v, input longint lo, input longint hi);
		longint r;
		r = (v + 32768) >>> 16;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	// bearing between the two fixes turned into yaw and quaternion
	function automatic heading_t predict_heading(input fix_pair_t f);
		heading_t h;
		longint s1, c1, s2, c2, sd, cd, ycomp, xcomp, qs, qc, rz, rw;
		logic [31:0] dl, theta, yaw;
		dl = deg7_turns(longint'(f.lon2)) - deg7_turns(longint'(f.lon1));
		rotate_angle(deg7_turns(longint'(f.lat1)), s1, c1);
		rotate_angle(deg7_turns(longint'(f.lat2)), s2, c2);
		rotate_angle(dl, sd, cd);
		ycomp = (c2 * sd) >>> 30;
		xcomp = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
		theta = vector_angle(ycomp, xcomp);
		yaw = (gbyq_pkg::QUARTER_TURN - theta) & YAW_KEEP;
		rotate_angle(yaw >> 1, qs, qc);
		rz = round_q14(qs, 0, 16384);
		rw = round_q14(qc, -16384, 16384);
		h.yaw = yaw[31:16];
		h.qz = rz[14:0];
		h.qw = rw[15:0];
		h.dlat = f.lat2;
		h.dlon = f.lon2;
		return h;
	endfunction

	function automatic fix_pair_t make_fixes(input longint a, input longint b, input longint c,
		input longint d);
		fix_pair_t f;
		f.lat1 = a[30:0];
		f.lon1 = b[31:0];
		f.lat2 = c[30:0];
		f.lon2 = d[31:0];
		return f;
	endfunction

	function automatic longint rand_lat();
		return longint'($urandom_range(1800000000)) - 900000000;
	endfunction

	function automatic longint rand_lon();
		return longint'($urandom_range(32'd3600000000)) - 1800000000;
	endfunction

	// append one fix pair to the send queue
	task automatic queue_fix(input fix_pair_t f);
		pending_fixes = {pending_fixes, f};
	endtask

	// sender: offer queued fix pairs, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_headings = {expected_headings,
					predict_heading({start_latitude, start_longitude,
					end_latitude, end_longitude})};
				fixes_sent <= fixes_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(15) == 0) begin
					send_gap <= $urandom_range(13) - 1;
					in_valid <= 1'b0;
				end else if (pending_fixes.size() > 0) begin
					fix_pair_t f;
					f = pending_fixes.pop_front();
					start_latitude <= f.lat1;
					start_longitude <= f.lon1;
					end_latitude <= f.lat2;
					end_longitude <= f.lon2;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the pipeline fills and backs up
	always @(posedge clk) begin
		if (!hold_done && fixes_sent >= 300) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(11) == 0) begin
			recv_gap <= $urandom_range(13) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_left > 1;
		end
	end

	// checker: compare each taken item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_headings.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected item: yaw %0d z %0d w %0d", yaw_turns, quat_z, quat_w);
			end else begin
				heading_t e;
				e = expected_headings.pop_front();
				if (e.yaw !== yaw_turns || e.qz !== quat_z || e.qw !== quat_w ||
					e.dlat !== datum_latitude || e.dlon !== datum_longitude) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("mismatch: exp yaw %0d z %0d w %0d lat %0d lon %0d,",
							e.yaw, e.qz, e.qw, e.dlat, e.dlon);
						$display("  got yaw %0d z %0d w %0d lat %0d lon %0d",
							yaw_turns, quat_z, quat_w, datum_latitude, datum_longitude);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		longint a, b;
		int pick;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, identical fixes, poles, antipodes, wrap of longitude
		queue_fix(make_fixes(0, 0, 0, 0));
		queue_fix(make_fixes(450000000, 100000000, 450000000, 100000000));
		queue_fix(make_fixes(0, 0, 0, 10000000));
		queue_fix(make_fixes(0, 0, 0, -10000000));
		queue_fix(make_fixes(0, 0, 10000000, 0));
		queue_fix(make_fixes(0, 0, -10000000, 0));
		queue_fix(make_fixes(-900000000, 0, 900000000, 0));
		queue_fix(make_fixes(900000000, 0, -900000000, 0));
		queue_fix(make_fixes(900000000, 1800000000, 900000000, -1800000000));
		queue_fix(make_fixes(0, -1800000000, 0, 1800000000));
		queue_fix(make_fixes(0, 1799999999, 0, -1799999999));
		queue_fix(make_fixes(0, 0, 0, 1800000000));
		queue_fix(make_fixes(300000000, 0, -300000000, 1800000000));
		queue_fix(make_fixes(-900000000, -1800000000, -900000000, 1800000000));
		queue_fix(make_fixes(899999999, 1, 899999999, 2));
		queue_fix(make_fixes(1, 0, 0, 0));
		queue_fix(make_fixes(-1, 0, 0, 0));
		queue_fix(make_fixes(32'h3FFF_FFFF, 32'h7FFF_FFFF,
			-64'sd1073741824, -64'sd2147483648));
		queue_fix(make_fixes(-64'sd1073741824, -64'sd2147483648,
			32'h3FFF_FFFF, 32'h7FFF_FFFF));
		queue_fix(make_fixes(-600000000, 1200000000, 600000000, -1200000000));

		// sender pause until every prediction is matched
		wait (pending_fixes.size() == 0 && !in_valid && expected_headings.size() == 0);
		@(posedge clk);

		// random part: mostly in range, some raw bit patterns and degenerate pairs
		for (int n = 0; n < 1000; n++) begin
			pick = $urandom_range(19);
			if (pick == 0)
				queue_fix(make_fixes($urandom, $urandom, $urandom, $urandom));
			else if (pick == 1) begin
				a = rand_lat();
				b = rand_lon();
				queue_fix(make_fixes(a, b, a, b));
			end else if (pick == 2) begin
				a = rand_lat();
				queue_fix(make_fixes(a, rand_lon(), -a, rand_lon()));
			end else if (pick == 3) begin
				a = rand_lat();
				b = rand_lon();
				queue_fix(make_fixes(a, b, a + $urandom_range(2000) - 1000,
					b + $urandom_range(2000) - 1000));
			end else
				queue_fix(make_fixes(rand_lat(), rand_lon(), rand_lat(), rand_lon()));
			if (n == 850) begin
				wait (pending_fixes.size() < 10);
				quiet = 1'b1;
			end
		end

		wait (pending_fixes.size() == 0 && !in_valid && expected_headings.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_headings.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
